@@ src/fbce_pkg.sv @@
package fbce_pkg;

    localparam int NIB_W     = 4;
    localparam int MEM_AW    = 2 * NIB_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef logic [NIB_W-1:0]  t_nib;
    typedef logic [MEM_AW-1:0] t_mem_addr;

    typedef enum logic [NIB_W-1:0] {
        OP_ADD_A    = 4'h0,
        OP_MOV_A_B  = 4'h1,
        OP_IN_A     = 4'h2,
        OP_MOV_A_IM = 4'h3,
        OP_MOV_B_A  = 4'h4,
        OP_ADD_B    = 4'h5,
        OP_IN_B     = 4'h6,
        OP_MOV_B_IM = 4'h7,
        OP_EXT      = 4'h8,
        OP_OUT_B    = 4'h9,
        OP_JZ       = 4'hA,
        OP_OUT_IM   = 4'hB,
        OP_MOV_Y    = 4'hC,
        OP_MOV_X    = 4'hD,
        OP_JNC      = 4'hE,
        OP_JMP      = 4'hF
    } t_opcode;

    typedef enum logic [NIB_W-1:0] {
        SUB_ADD_AB  = 4'h0,
        SUB_NEG     = 4'h1,
        SUB_NOT     = 4'h2,
        SUB_OR      = 4'h3,
        SUB_AND     = 4'h4,
        SUB_XOR     = 4'h5,
        SUB_SUB     = 4'h6,
        SUB_OUT_A   = 4'h7,
        SUB_LD_A    = 4'h8,
        SUB_ST_A    = 4'h9,
        SUB_LD_B    = 4'hA,
        SUB_ST_B    = 4'hB,
        SUB_MOV_X_A = 4'hC,
        SUB_MOV_Y_A = 4'hD,
        SUB_INC_XY  = 4'hE,
        SUB_JMP_Y   = 4'hF
    } t_subop;

    typedef struct packed {
        t_nib cmd;
        t_nib operand;
        t_nib in_port;
    } t_item;

    typedef struct packed {
        t_nib a;
        t_nib b;
        t_nib x;
        t_nib y;
        t_nib pc;
        logic zf;
        logic cp;
    } t_state;

    typedef struct packed {
        t_nib acc_a;
        t_nib acc_b;
        t_nib addr_hi;
        t_nib addr_lo;
        t_nib out_port;
        t_nib prog_count;
        logic zero_out;
        logic carry_seen;
        logic carry_next;
        logic jump_taken;
    } t_result;

    typedef struct packed {
        logic      we;
        t_mem_addr addr;
        t_nib      data;
    } t_mem_req;

    // 4-bit add with carry-out in the top bit
    function automatic logic [NIB_W:0] add_nib(input t_nib p, input t_nib q);
        return {1'b0, p} + {1'b0, q};
    endfunction

endpackage

@@ src/four_bit_cpu_execute_core.sv @@
// Executes one instruction of the extended 4-bit accumulator CPU per item and returns the
// register file, output port, PC and flags after that instruction. Throughput is one item per
// clock while the output is not stalled; a result is presented on the output once its item has
// passed the input register and then the result register, and a result held by a stalled output
// keeps the next item in the input register. The path between the registers is the 4-bit ALU
// and register update; the 256x4 data memory is read ahead at the X:Y address the next
// instruction will use, with a bypass for a store that hits that address. Valid bits for the
// memory clear at reset, so a load from a location never stored leaves its target register
// unchanged. No clearing pass is needed after reset.
module four_bit_cpu_execute_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cmd[3:0], operand[7:4], in_port[11:8], zero pad
    input  logic [fbce_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // acc_a[3:0], acc_b[7:4], addr_hi[11:8], addr_lo[15:12], out_port[19:16],
    // prog_count[23:20], zero_out[24], carry_seen[25], carry_next[26], jump_taken[27], zero pad
    output logic [fbce_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    logic                   r_in_valid;
    fbce_pkg::t_item        r_in;
    fbce_pkg::t_state       r_state;
    fbce_pkg::t_state       exec_state;
    fbce_pkg::t_state       n_state;
    fbce_pkg::t_result      exec_result;
    fbce_pkg::t_result      r_out;
    fbce_pkg::t_mem_req     mem_req;
    logic                   r_out_valid;
    logic [fbce_pkg::MEM_DEPTH-1:0] r_mem_valid;
    logic                   r_fwd_hit;
    fbce_pkg::t_nib         r_fwd_data;
    fbce_pkg::t_nib         ram_rdata;
    fbce_pkg::t_nib         mem_data;
    fbce_pkg::t_mem_addr    rd_addr;
    logic                   advance;
    logic                   mem_we;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign mem_we        = advance && mem_req.we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd     <= s_axis_tdata[3:0];
            r_in.operand <= s_axis_tdata[7:4];
            r_in.in_port <= s_axis_tdata[11:8];
        end
    end

    assign mem_data = r_fwd_hit ? r_fwd_data : ram_rdata;

    fbce_exec u_exec (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_mem_valid (r_mem_valid[{r_state.x, r_state.y}]),
        .i_mem_data  (mem_data),
        .o_state     (exec_state),
        .o_result    (exec_result),
        .o_mem       (mem_req)
    );

    assign n_state = advance ? exec_state : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= '0;
        end else if (mem_we) begin
            r_mem_valid[mem_req.addr] <= 1'b1;
        end
    end

    // prefetch at the address the next instruction will see
    assign rd_addr = !i_rst_n ? '0 : {n_state.x, n_state.y};

    fbce_ram #(
        .WIDTH (fbce_pkg::NIB_W),
        .DEPTH (fbce_pkg::MEM_DEPTH)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_req.addr),
        .i_wdata (mem_req.data),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // store to the address being prefetched: take the written data instead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else begin
            r_fwd_hit <= mem_we && (mem_req.addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= mem_req.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= exec_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.jump_taken, r_out.carry_next, r_out.carry_seen,
                            r_out.zero_out, r_out.prog_count, r_out.out_port, r_out.addr_lo,
                            r_out.addr_hi, r_out.acc_b, r_out.acc_a};

`ifndef ASSERT_OFF
    a_store_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_mem_valid[$past(mem_req.addr)])
        else $error("stored location not marked valid");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !advance) |=> $stable(r_state))
        else $error("cpu state changed without an instruction");

    a_fwd_needs_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> $past(mem_we))
        else $error("memory bypass without a store");

    a_result_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_state.cp == r_out.carry_next))
        else $error("pending carry does not match reported carry");
`endif

endmodule

@@ src/fbce_ram.sv @@
module fbce_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fbce_exec.sv @@
module fbce_exec (
    input  fbce_pkg::t_state   i_state,
    input  fbce_pkg::t_item    i_item,
    input  logic               i_mem_valid,
    input  fbce_pkg::t_nib     i_mem_data,
    output fbce_pkg::t_state   o_state,
    output fbce_pkg::t_result  o_result,
    output fbce_pkg::t_mem_req o_mem
);

    fbce_pkg::t_state         n;
    fbce_pkg::t_mem_req       mem;
    logic [fbce_pkg::NIB_W:0] sum;
    fbce_pkg::t_nib           outp;
    fbce_pkg::t_nib           op;
    logic                     cy;
    logic                     jmp;
    logic                     op_nz;

    assign op    = i_item.operand;
    assign op_nz = (op != '0);

    always_comb begin
        n        = i_state;
        n.pc     = i_state.pc + 4'd1;
        n.cp     = 1'b0;
        sum      = '0;
        outp     = '0;
        cy       = 1'b0;
        jmp      = 1'b0;
        mem.we   = 1'b0;
        mem.addr = {i_state.x, i_state.y};
        mem.data = i_state.a;

        case (fbce_pkg::t_opcode'(i_item.cmd))
            fbce_pkg::OP_ADD_A: begin
                sum  = fbce_pkg::add_nib(i_state.a, op);
                n.a  = sum[3:0];
                cy   = sum[4];
                n.zf = (sum[3:0] == '0);
            end
            fbce_pkg::OP_ADD_B: begin
                sum  = fbce_pkg::add_nib(i_state.b, op);
                n.b  = sum[3:0];
                cy   = sum[4];
                n.zf = (sum[3:0] == '0);
            end
            fbce_pkg::OP_MOV_A_IM: begin
                n.a  = op;
                n.zf = 1'b0;
            end
            fbce_pkg::OP_MOV_B_IM: begin
                n.b  = op;
                n.zf = 1'b0;
            end
            // a zero immediate makes these plain moves, which clear the zero flag
            fbce_pkg::OP_MOV_A_B: begin
                sum  = fbce_pkg::add_nib(i_state.b, op);
                n.a  = sum[3:0];
                cy   = sum[4];
                n.zf = op_nz && (sum[3:0] == '0);
            end
            fbce_pkg::OP_MOV_B_A: begin
                sum  = fbce_pkg::add_nib(i_state.a, op);
                n.b  = sum[3:0];
                cy   = sum[4];
                n.zf = op_nz && (sum[3:0] == '0);
            end
            fbce_pkg::OP_IN_A: begin
                sum  = fbce_pkg::add_nib(i_item.in_port, op);
                n.a  = sum[3:0];
                cy   = sum[4];
                n.zf = op_nz && (sum[3:0] == '0);
            end
            fbce_pkg::OP_IN_B: begin
                sum  = fbce_pkg::add_nib(i_item.in_port, op);
                n.b  = sum[3:0];
                cy   = sum[4];
                n.zf = op_nz && (sum[3:0] == '0);
            end
            fbce_pkg::OP_OUT_B: begin
                sum  = fbce_pkg::add_nib(i_state.b, op);
                outp = sum[3:0];
                cy   = sum[4];
                n.zf = op_nz && (sum[3:0] == '0);
            end
            fbce_pkg::OP_OUT_IM: begin
                outp = op;
                n.zf = 1'b0;
            end
            fbce_pkg::OP_MOV_Y: begin
                n.y  = op;
                n.zf = 1'b0;
            end
            fbce_pkg::OP_MOV_X: begin
                n.x  = op;
                n.zf = 1'b0;
            end
            fbce_pkg::OP_JMP: begin
                n.pc = op;
                jmp  = 1'b1;
            end
            fbce_pkg::OP_JNC: begin
                if (!i_state.cp) begin
                    n.pc = op;
                    jmp  = 1'b1;
                end
            end
            fbce_pkg::OP_JZ: begin
                if (i_state.zf) begin
                    n.pc = op;
                    jmp  = 1'b1;
                end
                n.zf = 1'b0;
            end
            fbce_pkg::OP_EXT: begin
                n.zf = 1'b0;
                case (fbce_pkg::t_subop'(op))
                    fbce_pkg::SUB_ADD_AB: begin
                        sum  = fbce_pkg::add_nib(i_state.a, i_state.b);
                        n.a  = sum[3:0];
                        cy   = sum[4];
                        n.zf = (sum[3:0] == '0);
                    end
                    // negation keeps the two's complement to a nibble and never sets the carry
                    fbce_pkg::SUB_NEG: begin
                        n.a  = 4'(~i_state.a + 4'd1);
                        n.zf = (i_state.a == '0);
                    end
                    fbce_pkg::SUB_NOT: begin
                        n.a  = ~i_state.a;
                        n.zf = (i_state.a == 4'hF);
                    end
                    fbce_pkg::SUB_OR: begin
                        n.a  = i_state.a | i_state.b;
                        n.zf = ((i_state.a | i_state.b) == '0);
                    end
                    fbce_pkg::SUB_AND: begin
                        n.a  = i_state.a & i_state.b;
                        n.zf = ((i_state.a & i_state.b) == '0);
                    end
                    fbce_pkg::SUB_XOR: begin
                        n.a  = i_state.a ^ i_state.b;
                        n.zf = ((i_state.a ^ i_state.b) == '0);
                    end
                    fbce_pkg::SUB_SUB: begin
                        sum  = fbce_pkg::add_nib(i_state.a, 4'(~i_state.b + 4'd1));
                        n.a  = sum[3:0];
                        cy   = sum[4];
                        n.zf = (sum[3:0] == '0);
                    end
                    fbce_pkg::SUB_OUT_A: begin
                        outp = i_state.a;
                    end
                    // unwritten locations leave the target untouched
                    fbce_pkg::SUB_LD_A: begin
                        if (i_mem_valid) begin
                            n.a = i_mem_data;
                        end
                    end
                    fbce_pkg::SUB_LD_B: begin
                        if (i_mem_valid) begin
                            n.b = i_mem_data;
                        end
                    end
                    fbce_pkg::SUB_ST_A: begin
                        mem.we   = 1'b1;
                        mem.data = i_state.a;
                    end
                    fbce_pkg::SUB_ST_B: begin
                        mem.we   = 1'b1;
                        mem.data = i_state.b;
                    end
                    fbce_pkg::SUB_MOV_X_A: begin
                        n.x = i_state.a;
                    end
                    fbce_pkg::SUB_MOV_Y_A: begin
                        n.y = i_state.a;
                    end
                    fbce_pkg::SUB_INC_XY: begin
                        {n.x, n.y} = {i_state.x, i_state.y} + 8'd1;
                    end
                    fbce_pkg::SUB_JMP_Y: begin
                        n.pc = i_state.y;
                        jmp  = 1'b1;
                    end
                    default: begin
                        n.zf = 1'b0;
                    end
                endcase
            end
            default: begin
                n.zf = 1'b0;
            end
        endcase

        n.cp = cy;
    end

    assign o_state = n;
    assign o_mem   = mem;

    assign o_result.acc_a      = n.a;
    assign o_result.acc_b      = n.b;
    assign o_result.addr_hi    = n.x;
    assign o_result.addr_lo    = n.y;
    assign o_result.out_port   = outp;
    assign o_result.prog_count = n.pc;
    assign o_result.zero_out   = n.zf;
    assign o_result.carry_seen = i_state.cp;
    assign o_result.carry_next = cy;
    assign o_result.jump_taken = jmp;

endmodule

@@ test/four_bit_cpu_execute_core_test.sv @@
`timescale 1ns / 1ps

module four_bit_cpu_execute_core_test;

    import fbce_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // cmd[3:0], operand[7:4], in_port[11:8], zero pad
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // acc_a[3:0], acc_b[7:4], addr_hi[11:8], addr_lo[15:12], out_port[19:16],
    // prog_count[23:20], zero_out[24], carry_seen[25], carry_next[26], jump_taken[27], zero pad
    logic [31:0] m_axis_tdata;

    four_bit_cpu_execute_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    typedef struct packed {
        t_item   it;
        logic    chk;
        t_result exp;
    } t_dir_row;

    // directed program; rows with chk set carry a hand-worked result
    t_dir_row dir_tab[$] = '{
        '{'{OP_MOV_A_IM, 4'hF, 4'h0}, 1'b1,
          '{4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'h1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_ADD_A, 4'h1, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h2, 1'b1, 1'b0, 1'b1, 1'b0}},
        // carry pending, so no jump; zero flag survives
        '{'{OP_JNC, 4'h7, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h3, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{OP_JZ, 4'h9, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h9, 1'b0, 1'b0, 1'b0, 1'b1}},
        // load from a location never stored leaves A alone
        '{'{OP_EXT, SUB_LD_A, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hA, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_JMP, 4'hF, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 1'b0, 1'b0, 1'b0, 1'b1}},
        // pc wraps to zero
        '{'{OP_EXT, SUB_INC_XY, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_EXT, SUB_LD_B, 4'h0}, 1'b1,
          '{4'h0, 4'h0, 4'h0, 4'h1, 4'h0, 4'h1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{OP_MOV_X, 4'hF, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_Y, 4'hF, 4'h0}, 1'b0, '0},
        // address ff wraps to 00
        '{'{OP_EXT, SUB_INC_XY, 4'h0}, 1'b0, '0},
        '{'{OP_IN_A, 4'h0, 4'hF}, 1'b0, '0},
        '{'{OP_EXT, SUB_ST_A, 4'h0}, 1'b0, '0},
        '{'{OP_IN_B, 4'h1, 4'hF}, 1'b0, '0},
        '{'{OP_ADD_B, 4'hF, 4'h5}, 1'b0, '0},
        '{'{OP_MOV_Y, 4'h3, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_ST_B, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_B_IM, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_LD_B, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_Y, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_A_IM, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_LD_A, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_A_B, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_A_B, 4'h1, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_B_A, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_B_A, 4'hF, 4'h0}, 1'b0, '0},
        '{'{OP_IN_B, 4'h0, 4'hA}, 1'b0, '0},
        '{'{OP_IN_A, 4'hF, 4'hF}, 1'b0, '0},
        '{'{OP_OUT_B, 4'h0, 4'h0}, 1'b0, '0},
        '{'{OP_OUT_B, 4'h6, 4'h0}, 1'b0, '0},
        '{'{OP_OUT_IM, 4'hF, 4'h0}, 1'b0, '0},
        '{'{OP_JZ, 4'h2, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_ADD_AB, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_NEG, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_NOT, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_OR, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_AND, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_XOR, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_SUB, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_OUT_A, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_MOV_X_A, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_MOV_Y_A, 4'h0}, 1'b0, '0},
        '{'{OP_EXT, SUB_JMP_Y, 4'h0}, 1'b0, '0},
        '{'{OP_MOV_A_IM, 4'h0, 4'h0}, 1'b0, '0},
        // negating zero
        '{'{OP_EXT, SUB_NEG, 4'h0}, 1'b0, '0},
        '{'{OP_JNC, 4'h5, 4'h0}, 1'b0, '0}
    };

    // shadow of the cpu
    t_nib cpu_a, cpu_b, cpu_x, cpu_y, cpu_pc;
    logic cpu_zf, cpu_cp;
    t_nib mem_shadow  [0:MEM_DEPTH-1];
    logic mem_written [0:MEM_DEPTH-1];

    t_result result_q[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_err = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_jumps = 0;
    int n_load_hits = 0;

    function automatic t_nib add4(input t_nib p, input t_nib q, output logic co);
        logic [NIB_W:0] s;
        s = {1'b0, p} + {1'b0, q};
        co = s[NIB_W];
        return s[NIB_W-1:0];
    endfunction

    function automatic t_result execute_instr(input t_item it);
        t_result   r;
        t_mem_addr addr;
        t_nib      outp, prev;
        logic      c_in, cy, jmp;
        c_in = cpu_cp;
        cy   = 1'b0;
        outp = '0;
        jmp  = 1'b0;
        addr = {cpu_x, cpu_y};
        cpu_pc = cpu_pc + 1'b1;
        case (t_opcode'(it.cmd))
            OP_ADD_A: begin
                cpu_a  = add4(cpu_a, it.operand, cy);
                cpu_zf = (cpu_a == 0);
            end
            OP_ADD_B: begin
                cpu_b  = add4(cpu_b, it.operand, cy);
                cpu_zf = (cpu_b == 0);
            end
            OP_MOV_A_IM: begin
                cpu_a  = it.operand;
                cpu_zf = 1'b0;
            end
            OP_MOV_B_IM: begin
                cpu_b  = it.operand;
                cpu_zf = 1'b0;
            end
            OP_MOV_A_B: begin
                if (it.operand == 0) begin
                    cpu_a  = cpu_b;
                    cpu_zf = 1'b0;
                end else begin
                    cpu_a  = add4(cpu_b, it.operand, cy);
                    cpu_zf = (cpu_a == 0);
                end
            end
            OP_MOV_B_A: begin
                if (it.operand == 0) begin
                    cpu_b  = cpu_a;
                    cpu_zf = 1'b0;
                end else begin
                    cpu_b  = add4(cpu_a, it.operand, cy);
                    cpu_zf = (cpu_b == 0);
                end
            end
            OP_IN_A: begin
                if (it.operand == 0) begin
                    cpu_a  = it.in_port;
                    cpu_zf = 1'b0;
                end else begin
                    cpu_a  = add4(it.in_port, it.operand, cy);
                    cpu_zf = (cpu_a == 0);
                end
            end
            OP_IN_B: begin
                if (it.operand == 0) begin
                    cpu_b  = it.in_port;
                    cpu_zf = 1'b0;
                end else begin
                    cpu_b  = add4(it.in_port, it.operand, cy);
                    cpu_zf = (cpu_b == 0);
                end
            end
            OP_OUT_B: begin
                if (it.operand == 0) begin
                    outp   = cpu_b;
                    cpu_zf = 1'b0;
                end else begin
                    outp   = add4(cpu_b, it.operand, cy);
                    cpu_zf = (outp == 0);
                end
            end
            OP_OUT_IM: begin
                outp   = it.operand;
                cpu_zf = 1'b0;
            end
            OP_MOV_Y: begin
                cpu_y  = it.operand;
                cpu_zf = 1'b0;
            end
            OP_MOV_X: begin
                cpu_x  = it.operand;
                cpu_zf = 1'b0;
            end
            OP_JMP: begin
                cpu_pc = it.operand;
                jmp    = 1'b1;
            end
            OP_JNC: begin
                if (!c_in) begin
                    cpu_pc = it.operand;
                    jmp    = 1'b1;
                end
            end
            OP_JZ: begin
                if (cpu_zf) begin
                    cpu_pc = it.operand;
                    jmp    = 1'b1;
                end
                cpu_zf = 1'b0;
            end
            default: begin
                cpu_zf = 1'b0;
                case (t_subop'(it.operand))
                    SUB_ADD_AB: begin
                        cpu_a  = add4(cpu_a, cpu_b, cy);
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_NEG: begin
                        prev   = cpu_a;
                        cpu_a  = -prev;
                        cpu_zf = (cpu_a == 0);
                        cy     = (cpu_a == 0) && (prev != 0);
                    end
                    SUB_NOT: begin
                        cpu_a  = ~cpu_a;
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_OR: begin
                        cpu_a  = cpu_a | cpu_b;
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_AND: begin
                        cpu_a  = cpu_a & cpu_b;
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_XOR: begin
                        cpu_a  = cpu_a ^ cpu_b;
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_SUB: begin
                        prev   = -cpu_b;
                        cpu_a  = add4(cpu_a, prev, cy);
                        cpu_zf = (cpu_a == 0);
                    end
                    SUB_OUT_A: outp = cpu_a;
                    SUB_LD_A: begin
                        if (mem_written[addr]) begin
                            cpu_a = mem_shadow[addr];
                            n_load_hits++;
                        end
                    end
                    SUB_LD_B: begin
                        if (mem_written[addr]) begin
                            cpu_b = mem_shadow[addr];
                            n_load_hits++;
                        end
                    end
                    SUB_ST_A: begin
                        mem_shadow[addr]  = cpu_a;
                        mem_written[addr] = 1'b1;
                    end
                    SUB_ST_B: begin
                        mem_shadow[addr]  = cpu_b;
                        mem_written[addr] = 1'b1;
                    end
                    SUB_MOV_X_A: cpu_x = cpu_a;
                    SUB_MOV_Y_A: cpu_y = cpu_a;
                    SUB_INC_XY: begin
                        addr = addr + 1'b1;
                        {cpu_x, cpu_y} = addr;
                    end
                    default: begin
                        cpu_pc = cpu_y;
                        jmp    = 1'b1;
                    end
                endcase
            end
        endcase
        cpu_cp = cy;
        if (jmp)
            n_jumps++;
        r.acc_a      = cpu_a;
        r.acc_b      = cpu_b;
        r.addr_hi    = cpu_x;
        r.addr_lo    = cpu_y;
        r.out_port   = outp;
        r.prog_count = cpu_pc;
        r.zero_out   = cpu_zf;
        r.carry_seen = c_in;
        r.carry_next = cy;
        r.jump_taken = jmp;
        return r;
    endfunction

    task automatic report(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int e, input int a);
        if (e != a)
            report($sformatf("%s mismatch: expected %h, got %h", name, e, a));
    endtask

    // starts and ends at a falling edge
    task automatic send_instr(input t_item it, input logic has_exp, input t_result typed);
        t_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, it.in_port, it.operand, it.cmd};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pred = execute_instr(it);
        result_q.push_back(has_exp ? typed : pred);
        n_sent++;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                report($sformatf("result %h with nothing expected", m_axis_tdata));
            end else begin
                e = result_q.pop_front();
                n_checked++;
                check_field("acc_a",      e.acc_a,      m_axis_tdata[3:0]);
                check_field("acc_b",      e.acc_b,      m_axis_tdata[7:4]);
                check_field("addr_hi",    e.addr_hi,    m_axis_tdata[11:8]);
                check_field("addr_lo",    e.addr_lo,    m_axis_tdata[15:12]);
                check_field("out_port",   e.out_port,   m_axis_tdata[19:16]);
                check_field("prog_count", e.prog_count, m_axis_tdata[23:20]);
                check_field("zero_out",   e.zero_out,   m_axis_tdata[24]);
                check_field("carry_seen", e.carry_seen, m_axis_tdata[25]);
                check_field("carry_next", e.carry_next, m_axis_tdata[26]);
                check_field("jump_taken", e.jump_taken, m_axis_tdata[27]);
            end
        end
    end

    initial begin
        #400_000;
        $display("four_bit_cpu_execute_core_test: errors");
        $finish;
    end

    initial begin
        t_item it;
        int    r;
        {cpu_a, cpu_b, cpu_x, cpu_y, cpu_pc} = '0;
        cpu_zf = 1'b0;
        cpu_cp = 1'b0;
        for (int i = 0; i < MEM_DEPTH; i++) begin
            mem_shadow[i]  = '0;
            mem_written[i] = 1'b0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[k])
            send_instr(dir_tab[k].it, dir_tab[k].chk, dir_tab[k].exp);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            repeat (130) begin
                r = $urandom_range(99);
                it.cmd     = $urandom_range(15);
                it.operand = $urandom_range(15);
                it.in_port = $urandom_range(15);
                if (r < 30)
                    it.cmd = OP_EXT;
                // keep X:Y in a small window most of the time so loads find stores
                if (it.cmd == OP_MOV_X && r < 80)
                    it.operand = $urandom_range(1);
                if (it.cmd == OP_MOV_Y && r < 80)
                    it.operand = $urandom_range(3);
                send_instr(it, 1'b0, '0);
            end
        end
        s_axis_tvalid  <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d instructions executed (%0d from the directed program), %0d results checked",
                 n_sent, dir_tab.size(), n_checked);
        $display("%0d jumps taken, %0d loads from stored locations, %0d mismatches",
                 n_jumps, n_load_hits, n_err);
        if (n_err == 0)
            $display("four_bit_cpu_execute_core_test: clean");
        else
            $display("four_bit_cpu_execute_core_test: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
src/fbce_pkg.sv
src/fbce_ram.sv
src/fbce_exec.sv
src/four_bit_cpu_execute_core.sv
test/four_bit_cpu_execute_core_test.sv
